>>> hdl/pgdmd_pkg.sv
// Package with the types, constants and shared arithmetic of the dual motor drive.
`default_nettype none

package pgdmd_pkg;

	// Field widths.
	localparam int CODE_W = 10;
	localparam int RPM_W = 10;
	localparam int PWM_W = 8;
	localparam int GAIN_W = 4;
	localparam int TARGET_W = 11;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 10;

	// Internal widths.
	localparam int KNOB_PROD_W = CODE_W + RPM_W;
	localparam int ERR_PROD_W = CODE_W + PWM_W;
	localparam int CORR_PROD_W = ERR_PROD_W + GAIN_W;
	localparam int FOLD_W = 24;
	localparam int Q1_W = 13;
	localparam int CORR_MAG_W = 14;
	localparam int CORR_W = CORR_MAG_W + 1;
	localparam int RAW_TGT_W = Q1_W + 3;
	localparam int DIVIDEND_W = RPM_W + PWM_W;
	localparam int DIV_STATE_W = RPM_W + DIVIDEND_W;
	localparam int DIV_STEPS = 6;
	localparam int SUM_W = DIVIDEND_W + 2;

	// Pipeline depth: registers from input to output.
	localparam int NUM_STAGES = 8;

	// Saturation limit of the speed target.
	localparam int TARGET_LIMIT = 1023;

	// Divide by three of an 8-bit value as multiply and shift.
	localparam int THIRD_MUL = 171;
	localparam int THIRD_SHIFT = 9;
	localparam int THIRD_PROD_W = 16;

	// Reset values of the registers.
	localparam logic [RPM_W-1:0] RPM_MAX_RST = 10'd150;
	localparam logic [PWM_W-1:0] PWM_MAX_RST = 8'd255;
	localparam logic [CODE_W-1:0] SETPOINT_RST = 10'd900;
	localparam logic [CODE_W-1:0] P_HIGH_RST = 10'd980;
	localparam logic [CODE_W-1:0] P_LOW_RST = 10'd850;
	localparam logic [GAIN_W-1:0] GAIN_RST = 4'd3;

	typedef enum logic [1:0] {
		REGION_REG = 2'd0,
		REGION_LOW = 2'd1,
		REGION_HIGH = 2'd2
	} region_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_UP = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RPM_MAX = 3'd0,
		CFG_PWM_MAX = 3'd1,
		CFG_SETPOINT = 3'd2,
		CFG_P_HIGH = 3'd3,
		CFG_P_LOW = 3'd4,
		CFG_GAIN = 3'd5
	} cfg_idx_t;

	// Several steps of a restoring divider. The state holds the partial
	// remainder on top and the dividend bits, shifting into quotient bits, below.
	function automatic logic [DIV_STATE_W-1:0] div_steps(
		input logic [DIV_STATE_W-1:0] st,
		input logic [RPM_W-1:0] d
	);
		logic [RPM_W-1:0] rem;
		logic [DIVIDEND_W-1:0] dq;
		logic [RPM_W:0] cand;
		logic ge;
		rem = st[DIV_STATE_W-1 -: RPM_W];
		dq = st[DIVIDEND_W-1:0];
		for (int i = 0; i < DIV_STEPS; i++) begin
			cand = {rem, dq[DIVIDEND_W-1]};
			ge = (cand >= {1'b0, d});
			if (ge) begin
				rem = RPM_W'(cand - {1'b0, d});
			end else begin
				rem = cand[RPM_W-1:0];
			end
			dq = {dq[DIVIDEND_W-2:0], ge};
		end
		return {rem, dq};
	endfunction

endpackage

`default_nettype wire

>>> hdl/pressure_guarded_dual_motor_drive.sv
// Top level of the pressure-guarded dual motor drive pipeline.
`default_nettype none

// Each transaction on the input channel carries one pressure sample and one
// speed knob code and yields exactly one result transaction with region,
// signed speed target and direction and PWM duty for the lower and upper
// motor. The block is an eight-stage pipeline that accepts one item every
// cycle unless the output side stalls; the clock edge that accepts an item
// loads the first stage, and the result passes through the later stages and
// is presented from the eighth. The divisions by the converter full scale are
// done by folding shifts and adds in one stage each, and the division by
// rpm_max is a restoring divider spread over three stages of six quotient
// bits each, which sets the pipeline depth. Every stage holds its item while
// the output is stalled and bubbles close up, so input is taken while a
// finished result still waits. Registers are written through the
// configuration channel, which is always ready; write them only while no
// item is in flight.
module pressure_guarded_dual_motor_drive
	import pgdmd_pkg::*;
#(
	parameter int ADC_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic in_valid,
	output logic in_ready,
	input wire logic [CODE_W-1:0] pressure_sample,
	input wire logic [CODE_W-1:0] speed_knob,

	output logic out_valid,
	input wire logic out_ready,
	output logic [1:0] region,
	output logic signed [TARGET_W-1:0] speed_target,
	output logic [1:0] lower_dir,
	output logic [PWM_W-1:0] lower_pwm,
	output logic [1:0] upper_dir,
	output logic [PWM_W-1:0] upper_pwm,

	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [FOLD_W-1:0] ADC_MAX = FOLD_W'((1 << ADC_BITS) - 1);

	// Exact floor division by the converter full scale 2^ADC_BITS - 1.
	// Each fold uses x = a*2^N + b = a*(2^N - 1) + (a + b).
	function automatic logic [FOLD_W-1:0] div_adc(input logic [FOLD_W-1:0] x);
		logic [FOLD_W-1:0] y;
		logic [FOLD_W-1:0] a;
		logic [FOLD_W-1:0] q;
		y = x;
		q = '0;
		for (int k = 0; k < 3; k++) begin
			a = y >> ADC_BITS;
			y = a + (y & ADC_MAX);
			q = q + a;
		end
		if (y >= ADC_MAX) begin
			q = q + 1'b1;
		end
		return q;
	endfunction

	// Configuration registers.
	logic [RPM_W-1:0] rpm_max_q;
	logic [PWM_W-1:0] pwm_max_q;
	logic [CODE_W-1:0] setpoint_q;
	logic [CODE_W-1:0] p_high_q;
	logic [CODE_W-1:0] p_low_q;
	logic [GAIN_W-1:0] gain_q;

	assign cfg_ready = 1'b1;

	// Register writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_max_q <= RPM_MAX_RST;
			pwm_max_q <= PWM_MAX_RST;
			setpoint_q <= SETPOINT_RST;
			p_high_q <= P_HIGH_RST;
			p_low_q <= P_LOW_RST;
			gain_q <= GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RPM_MAX: rpm_max_q <= cfg_data[RPM_W-1:0];
				CFG_PWM_MAX: pwm_max_q <= cfg_data[PWM_W-1:0];
				CFG_SETPOINT: setpoint_q <= cfg_data[CODE_W-1:0];
				CFG_P_HIGH: p_high_q <= cfg_data[CODE_W-1:0];
				CFG_P_LOW: p_low_q <= cfg_data[CODE_W-1:0];
				CFG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control: a stage loads when it is empty or the next one moves.
	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] adv;

	always_comb begin
		adv[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready = adv[0];
	assign out_valid = vld_q[NUM_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: region tests, knob product and pressure error product.
	region_t region_c1;
	logic err_neg_c1;
	logic [CODE_W-1:0] err_mag_c1;

	always_comb begin
		if (pressure_sample < p_low_q) begin
			region_c1 = REGION_LOW;
		end else if (pressure_sample > p_high_q) begin
			region_c1 = REGION_HIGH;
		end else begin
			region_c1 = REGION_REG;
		end
		err_neg_c1 = pressure_sample > setpoint_q;
		if (err_neg_c1) begin
			err_mag_c1 = pressure_sample - setpoint_q;
		end else begin
			err_mag_c1 = setpoint_q - pressure_sample;
		end
	end

	region_t region_s1;
	logic err_neg_s1;
	logic [KNOB_PROD_W-1:0] knob_prod_s1;
	logic [ERR_PROD_W-1:0] err_prod_s1;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			region_s1 <= region_c1;
			err_neg_s1 <= err_neg_c1;
			knob_prod_s1 <= speed_knob * rpm_max_q;
			err_prod_s1 <= err_mag_c1 * pwm_max_q;
		end
	end

	// Stage 2: knob quotient by full scale, gain on the error product.
	logic [FOLD_W-1:0] q1_c2;

	assign q1_c2 = div_adc(FOLD_W'(knob_prod_s1));

	region_t region_s2;
	logic err_neg_s2;
	logic [Q1_W-1:0] q1_s2;
	logic [CORR_PROD_W-1:0] corr_prod_s2;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			region_s2 <= region_s1;
			err_neg_s2 <= err_neg_s1;
			q1_s2 <= q1_c2[Q1_W-1:0];
			corr_prod_s2 <= err_prod_s1 * gain_q;
		end
	end

	// Stage 3: signed speed target with saturation, direction and correction.
	logic signed [RAW_TGT_W-1:0] tgt_raw_c3;
	logic signed [TARGET_W-1:0] tgt_c3;
	dir_t dir_c3;
	logic [FOLD_W-1:0] corr_q_c3;
	logic [CORR_MAG_W-1:0] corr_mag_c3;
	logic signed [CORR_W-1:0] corr_c3;

	always_comb begin
		tgt_raw_c3 = $signed({2'b00, q1_s2, 1'b0}) -
			$signed({(RAW_TGT_W - RPM_W)'(0), rpm_max_q});
		if (region_s2 != REGION_REG) begin
			tgt_c3 = '0;
		end else if (tgt_raw_c3 > RAW_TGT_W'(TARGET_LIMIT)) begin
			tgt_c3 = TARGET_W'(TARGET_LIMIT);
		end else if (tgt_raw_c3 < -RAW_TGT_W'(TARGET_LIMIT)) begin
			tgt_c3 = -TARGET_W'(TARGET_LIMIT);
		end else begin
			tgt_c3 = tgt_raw_c3[TARGET_W-1:0];
		end
		dir_c3 = (tgt_c3 > 0) ? DIR_UP : DIR_DOWN;
		corr_q_c3 = div_adc(FOLD_W'(corr_prod_s2));
		corr_mag_c3 = corr_q_c3[CORR_MAG_W-1:0];
		if (err_neg_s2) begin
			corr_c3 = -$signed({1'b0, corr_mag_c3});
		end else begin
			corr_c3 = $signed({1'b0, corr_mag_c3});
		end
	end

	region_t region_s3;
	logic signed [TARGET_W-1:0] tgt_s3;
	dir_t dir_s3;
	logic signed [CORR_W-1:0] corr_s3;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			region_s3 <= region_s2;
			tgt_s3 <= tgt_c3;
			dir_s3 <= dir_c3;
			corr_s3 <= corr_c3;
		end
	end

	// Stage 4: target magnitude times pwm_max seeds the divider.
	logic [TARGET_W-1:0] mag_full_c4;
	logic [RPM_W-1:0] mag_c4;

	always_comb begin
		if (tgt_s3 < 0) begin
			mag_full_c4 = -tgt_s3;
		end else begin
			mag_full_c4 = tgt_s3;
		end
		mag_c4 = mag_full_c4[RPM_W-1:0];
	end

	region_t region_s4;
	logic signed [TARGET_W-1:0] tgt_s4;
	dir_t dir_s4;
	logic signed [CORR_W-1:0] corr_s4;
	logic [DIV_STATE_W-1:0] div_s4;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			region_s4 <= region_s3;
			tgt_s4 <= tgt_s3;
			dir_s4 <= dir_s3;
			corr_s4 <= corr_s3;
			div_s4 <= {RPM_W'(0), DIVIDEND_W'(mag_c4 * pwm_max_q)};
		end
	end

	// Stages 5 to 7: restoring division by rpm_max, six quotient bits each.
	region_t region_s5, region_s6, region_s7;
	logic signed [TARGET_W-1:0] tgt_s5, tgt_s6, tgt_s7;
	dir_t dir_s5, dir_s6, dir_s7;
	logic signed [CORR_W-1:0] corr_s5, corr_s6, corr_s7;
	logic [DIV_STATE_W-1:0] div_s5, div_s6, div_s7;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			region_s5 <= region_s4;
			tgt_s5 <= tgt_s4;
			dir_s5 <= dir_s4;
			corr_s5 <= corr_s4;
			div_s5 <= div_steps(div_s4, rpm_max_q);
		end
		if (adv[5]) begin
			region_s6 <= region_s5;
			tgt_s6 <= tgt_s5;
			dir_s6 <= dir_s5;
			corr_s6 <= corr_s5;
			div_s6 <= div_steps(div_s5, rpm_max_q);
		end
		if (adv[6]) begin
			region_s7 <= region_s6;
			tgt_s7 <= tgt_s6;
			dir_s7 <= dir_s6;
			corr_s7 <= corr_s6;
			div_s7 <= div_steps(div_s6, rpm_max_q);
		end
	end

	// Stage 8: saturate both duties and select the outputs of the region.
	logic [DIVIDEND_W-1:0] base_c8;
	logic signed [SUM_W-1:0] sum_c8;
	logic [THIRD_PROD_W-1:0] third_prod_c8;
	region_t region_c8;
	logic signed [TARGET_W-1:0] tgt_c8;
	dir_t ldir_c8, udir_c8;
	logic [PWM_W-1:0] lpwm_c8, upwm_c8;

	always_comb begin
		base_c8 = (rpm_max_q == '0) ? '0 : div_s7[DIVIDEND_W-1:0];
		sum_c8 = $signed({2'b00, base_c8}) + SUM_W'(corr_s7);
		third_prod_c8 = THIRD_PROD_W'(pwm_max_q * THIRD_PROD_W'(THIRD_MUL));
		region_c8 = region_s7;
		tgt_c8 = tgt_s7;
		unique case (region_s7)
			REGION_LOW: begin
				ldir_c8 = DIR_STOP;
				udir_c8 = DIR_STOP;
				lpwm_c8 = '0;
				upwm_c8 = '0;
			end
			REGION_HIGH: begin
				ldir_c8 = DIR_UP;
				udir_c8 = DIR_DOWN;
				lpwm_c8 = pwm_max_q >> 1;
				upwm_c8 = PWM_W'(third_prod_c8 >> THIRD_SHIFT);
			end
			default: begin
				ldir_c8 = dir_s7;
				udir_c8 = dir_s7;
				if (base_c8 > DIVIDEND_W'(pwm_max_q)) begin
					lpwm_c8 = pwm_max_q;
				end else begin
					lpwm_c8 = base_c8[PWM_W-1:0];
				end
				if (sum_c8 < 0) begin
					upwm_c8 = '0;
				end else if (sum_c8 > $signed({(SUM_W - PWM_W)'(0), pwm_max_q})) begin
					upwm_c8 = pwm_max_q;
				end else begin
					upwm_c8 = sum_c8[PWM_W-1:0];
				end
			end
		endcase
	end

	region_t region_s8;
	logic signed [TARGET_W-1:0] tgt_s8;
	dir_t ldir_s8, udir_s8;
	logic [PWM_W-1:0] lpwm_s8, upwm_s8;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			region_s8 <= region_c8;
			tgt_s8 <= tgt_c8;
			ldir_s8 <= ldir_c8;
			udir_s8 <= udir_c8;
			lpwm_s8 <= lpwm_c8;
			upwm_s8 <= upwm_c8;
		end
	end

	assign region = region_s8;
	assign speed_target = tgt_s8;
	assign lower_dir = ldir_s8;
	assign lower_pwm = lpwm_s8;
	assign upper_dir = udir_s8;
	assign upper_pwm = upwm_s8;

endmodule

`default_nettype wire

>>> sim/pressure_guarded_dual_motor_drive_test.sv
// Self-checking testbench for the pressure-guarded dual motor drive pipeline.
module pressure_guarded_dual_motor_drive_test;
	import pgdmd_pkg::*;

	// Converter full scale at the default ADC width.
	localparam int CODE_FULL = (1 << CODE_W) - 1;
	localparam int CODE_TOP = CODE_FULL;

	// One sensor tick as it enters the block.
	typedef struct packed {
		logic [CODE_W-1:0] pressure;
		logic [CODE_W-1:0] knob;
	} sample_t;

	// The drive that one tick produces.
	typedef struct packed {
		region_t region;
		logic signed [TARGET_W-1:0] target;
		dir_t lower_dir;
		logic [PWM_W-1:0] lower_pwm;
		dir_t upper_dir;
		logic [PWM_W-1:0] upper_pwm;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic [CODE_W-1:0] pressure_sample = '0;
	logic [CODE_W-1:0] speed_knob = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] region;
	logic signed [TARGET_W-1:0] speed_target;
	logic [1:0] lower_dir;
	logic [PWM_W-1:0] lower_pwm;
	logic [1:0] upper_dir;
	logic [PWM_W-1:0] upper_pwm;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Register copies used by the predictor.
	logic [RPM_W-1:0] drive_rpm_max = RPM_MAX_RST;
	logic [PWM_W-1:0] drive_pwm_max = PWM_MAX_RST;
	logic [CODE_W-1:0] drive_setpoint = SETPOINT_RST;
	logic [CODE_W-1:0] drive_p_high = P_HIGH_RST;
	logic [CODE_W-1:0] drive_p_low = P_LOW_RST;
	logic [GAIN_W-1:0] drive_gain = GAIN_RST;

	sample_t pending_samples[$];
	drive_t expected_drive[$];
	sample_t next_sample;
	drive_t oldest_drive;

	int items_issued = 0;
	int results_seen = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	pressure_guarded_dual_motor_drive DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pressure_sample(pressure_sample),
		.speed_knob(speed_knob),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.region(region),
		.speed_target(speed_target),
		.lower_dir(lower_dir),
		.lower_pwm(lower_pwm),
		.upper_dir(upper_dir),
		.upper_pwm(upper_pwm),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int limit_to(input int v, input int lo, input int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Expected drive for one tick under the current register copies.
	function automatic drive_t predict_drive(input logic [CODE_W-1:0] pres_code,
		input logic [CODE_W-1:0] knob_code);
		drive_t d;
		int pres, rmax, pmax, tgt, mag, base, corr;
		pres = pres_code;
		rmax = drive_rpm_max;
		pmax = drive_pwm_max;
		d.region = REGION_REG;
		d.target = '0;
		d.lower_dir = DIR_STOP;
		d.lower_pwm = '0;
		d.upper_dir = DIR_STOP;
		d.upper_pwm = '0;
		if (pres < int'(drive_p_low)) begin
			// The stop test wins even when the high test also holds.
			d.region = REGION_LOW;
		end else if (pres > int'(drive_p_high)) begin
			d.region = REGION_HIGH;
			d.lower_dir = DIR_UP;
			d.lower_pwm = PWM_W'(pmax / 2);
			d.upper_dir = DIR_DOWN;
			d.upper_pwm = PWM_W'(pmax / 3);
		end else begin
			tgt = (int'(knob_code) * rmax / CODE_FULL) * 2 - rmax;
			tgt = limit_to(tgt, -TARGET_LIMIT, TARGET_LIMIT);
			mag = (tgt < 0) ? -tgt : tgt;
			// A zero full-scale speed gives no base duty at all.
			base = (rmax != 0) ? (mag * pmax / rmax) : 0;
			// Signed division truncates toward zero.
			corr = (int'(drive_setpoint) - pres) * pmax * int'(drive_gain) / CODE_FULL;
			d.target = TARGET_W'(tgt);
			d.lower_dir = (tgt > 0) ? DIR_UP : DIR_DOWN;
			d.upper_dir = d.lower_dir;
			d.lower_pwm = PWM_W'(limit_to(base, 0, pmax));
			d.upper_pwm = PWM_W'(limit_to(base + corr, 0, pmax));
		end
		return d;
	endfunction

	task automatic check_field(input string name, input logic signed [31:0] want,
		input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Input driver: presents queued ticks and records the expected drive of each
	// accepted transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_drive.push_back(predict_drive(pressure_sample, speed_knob));
			end
			if (!in_valid || in_ready) begin
				if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_sample = pending_samples.pop_front();
					in_valid <= 1'b1;
					pressure_sample <= next_sample.pressure;
					speed_knob <= next_sample.knob;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each result transaction against the oldest
	// expectation and stalls the output at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_drive.size() == 0) begin
					$error("result transaction with no expectation waiting");
					mismatches++;
				end else begin
					oldest_drive = expected_drive.pop_front();
					check_field("region", oldest_drive.region, region);
					check_field("speed_target", oldest_drive.target, speed_target);
					check_field("lower_dir", oldest_drive.lower_dir, lower_dir);
					check_field("lower_pwm", oldest_drive.lower_pwm, lower_pwm);
					check_field("upper_dir", oldest_drive.upper_dir, upper_dir);
					check_field("upper_pwm", oldest_drive.upper_pwm, upper_pwm);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_sample(input int pres, input int knob);
		pending_samples.push_back('{pressure: CODE_W'(pres), knob: CODE_W'(knob)});
		items_issued++;
	endtask

	// Holds the sender back until every issued tick has produced its result.
	task automatic drain();
		while (results_seen < items_issued) @(posedge clk);
	endtask

	// One register write transaction; the predictor copy follows on acceptance.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_RPM_MAX: drive_rpm_max = data[RPM_W-1:0];
			CFG_PWM_MAX: drive_pwm_max = data[PWM_W-1:0];
			CFG_SETPOINT: drive_setpoint = data[CODE_W-1:0];
			CFG_P_HIGH: drive_p_high = data[CODE_W-1:0];
			CFG_P_LOW: drive_p_low = data[CODE_W-1:0];
			CFG_GAIN: drive_gain = data[GAIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int rpm, input int pwm, input int setpoint,
		input int p_high, input int p_low, input int gain);
		write_reg(CFG_RPM_MAX, CFG_DATA_W'(rpm));
		write_reg(CFG_PWM_MAX, CFG_DATA_W'(pwm));
		write_reg(CFG_SETPOINT, CFG_DATA_W'(setpoint));
		write_reg(CFG_P_HIGH, CFG_DATA_W'(p_high));
		write_reg(CFG_P_LOW, CFG_DATA_W'(p_low));
		write_reg(CFG_GAIN, CFG_DATA_W'(gain));
	endtask

	// Pressure code scattered a little around one threshold.
	function automatic int near_code(input int center);
		return limit_to(center + int'($urandom_range(40)) - 20, 0, CODE_TOP);
	endfunction

	// Random ticks biased toward the thresholds and the regulated band, with a
	// full pause of the sender halfway through.
	task automatic run_random(input int count);
		int pres, knob, lo, hi;
		lo = drive_p_low;
		hi = drive_p_high;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: pres = $urandom_range(CODE_TOP);
				1: pres = near_code(lo);
				2: pres = near_code(hi);
				default: pres = (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(CODE_TOP);
			endcase
			if ($urandom_range(15) == 0) begin
				knob = $urandom_range(1) ? CODE_TOP : 0;
			end else begin
				knob = $urandom_range(CODE_TOP);
			end
			push_sample(pres, knob);
			if (i == count / 2) drain();
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 22;
		recv_idle_pct = 48;

		// Directed ticks at the reset register values: both thresholds and
		// their neighbors, knob extremes, the knob that gives a zero target,
		// and corrections that saturate the upper duty at pwm_max.
		push_sample(0, 0);
		push_sample(CODE_TOP, CODE_TOP);
		push_sample(849, CODE_TOP);
		push_sample(850, 0);
		push_sample(850, CODE_TOP);
		push_sample(980, CODE_TOP);
		push_sample(981, 0);
		push_sample(980, 0);
		push_sample(900, 512);
		push_sample(900, 511);
		push_sample(900, 513);
		push_sample(900, CODE_TOP);
		push_sample(965, 700);
		push_sample(855, 300);
		drain();

		// Zero full-scale speed.
		apply_setting(0, 255, 900, 980, 850, 3);
		push_sample(900, CODE_TOP);
		push_sample(900, 0);
		push_sample(850, 700);
		drain();

		// Zero largest duty, in the regulated and both separate regions.
		apply_setting(1023, 0, 900, 980, 850, 3);
		push_sample(900, CODE_TOP);
		push_sample(1000, 5);
		push_sample(700, 5);
		drain();

		// Low threshold above the high one: the stop test must win.
		apply_setting(150, 255, 900, 400, 600, 15);
		push_sample(500, 100);
		push_sample(300, CODE_TOP);
		push_sample(700, CODE_TOP);
		drain();

		// Random part over three idling patterns and four register settings.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 22;
					recv_idle_pct = 48;
				end
				1: begin
					send_idle_pct = 48;
					recv_idle_pct = 22;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int setting = 0; setting < 4; setting++) begin
				case (setting)
					0: apply_setting(RPM_MAX_RST, PWM_MAX_RST, SETPOINT_RST, P_HIGH_RST,
						P_LOW_RST, GAIN_RST);
					1: apply_setting(1023, 255, 1023, 1023, 0, 15);
					2: apply_setting(1, 1, 0, 0, 0, 0);
					default: apply_setting($urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023), $urandom_range(1023), $urandom_range(1023),
						$urandom_range(1023));
				endcase
				run_random(54);
				drain();
			end
		end

		repeat (2 * NUM_STAGES) @(posedge clk);
		if (mismatches == 0 && expected_drive.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
